### hdl/cbe_pkg.sv
// ---------------------------------------------------------------------------
// Character buffer editor package
// Shared types, codes and default sizes for the character buffer editor
// with bounded undo history.
// ---------------------------------------------------------------------------
package cbe_pkg;

  // Default sizes for the top-level parameters.
  localparam int TEXT_CAPACITY_DEF = 64;
  localparam int UNDO_DEPTH_DEF    = 16;

  // Field widths fixed by the interface.
  localparam int POS_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 7;
  localparam int DEPTH_W = 5;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_UNDO   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  // Result status codes.
  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_ERR = 1'b1;

  // Undo record kinds.
  localparam logic REC_INSERT = 1'b0;
  localparam logic REC_DELETE = 1'b1;

  // Input item.
  typedef struct packed {
    cmd_t              cmd;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_in;
  } in_t;

  // Result item.
  typedef struct packed {
    logic               status;
    logic [CHAR_W-1:0]  char_out;
    logic               char_valid;
    logic [DEPTH_W-1:0] undo_depth;
    logic               last;
  } out_t;

  // One entry of the undo history.
  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } undo_rec_t;

  // Operation applied by every cell of the text row.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  // Control broadcast along the cell row.
  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
  } cell_ctl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNDO,
    ST_REPORT
  } state_t;

endpackage

### hdl/cbe_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cbe_cell.sv
// ---------------------------------------------------------------------------
// Text cell
// Holds one character of the string and takes a neighbour's character when
// the row opens a gap, closes a gap or rotates for a report.
// ---------------------------------------------------------------------------
module cbe_cell
  import cbe_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CHAR_W-1:0] left_data,
  input  logic [CHAR_W-1:0] right_data,
  input  logic [CHAR_W-1:0] first_data,
  output logic [CHAR_W-1:0] data_r
);

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  logic [CHAR_W-1:0] data_nxt;
  logic [LEN_W-1:0]  pos_ext;

  assign pos_ext = {1'b0, ctl.pos};

  // Choose this cell's next character from the broadcast operation.
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_INS: begin
        if (MY_IDX > pos_ext) begin
          data_nxt = left_data;
        end else if (MY_IDX == pos_ext) begin
          data_nxt = ctl.ch;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= pos_ext) begin
          data_nxt = right_data;
        end
      end
      CELL_ROT: begin
        if (MY_IDX + 1'b1 == ctl.len) begin
          data_nxt = first_data;
        end else if (MY_IDX + 1'b1 < ctl.len) begin
          data_nxt = right_data;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### hdl/char_buffer_edit_with_undo.sv
// ---------------------------------------------------------------------------
// Character buffer editor with undo
// Bounded string held in a row of character cells, with a bounded undo
// history in RAM. Insert, delete, undo and report commands.
//
//   Channel  | Ports                     | Transfer
//   ---------+---------------------------+---------------------------------
//   Input    | start, busy, in_data      | edge with start high, busy low
//   Result   | out_valid, out_data       | every cycle out_valid is high
//
// Insert and delete shift the whole row at once; the result appears in the
// next cycle and busy stays low, so edits can follow each other in
// consecutive cycles. Undo passes through the undo state, which waits on the
// registered read of the history RAM. Report streams the characters in
// order, cell 0 being read while the row rotates; an empty string gives a
// single result. Reset is synchronous and clears the length and history
// pointers; stored characters and records need no clearing. The receiver
// cannot stall; busy holds off the sender.
// ---------------------------------------------------------------------------
module char_buffer_edit_with_undo
  import cbe_pkg::*;
#(
  parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
  parameter int UNDO_DEPTH    = UNDO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int UW = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
  localparam int CW = $clog2(UNDO_DEPTH + 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(TEXT_CAPACITY - 1);
  localparam logic [UW-1:0]    TOP_LAST = UW'(UNDO_DEPTH - 1);
  localparam logic [CW-1:0]    CNT_FULL = CW'(UNDO_DEPTH);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [UW-1:0]    top_r, top_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [POS_W-1:0] rpt_r, rpt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, res_base, res_nxt;

  logic [UW-1:0]    top_inc, top_dec;
  logic [CW-1:0]    cnt_push;
  logic [CW+4:0]    cnt_ext;
  logic [LEN_W-1:0] pos_ext, rec_pos_ext;
  logic             accept, ins_ok, del_ok, rpt_last;

  cell_ctl_t         cell_ctl;
  logic [CHAR_W-1:0] cell_data [TEXT_CAPACITY];
  logic [CHAR_W-1:0] gone_ch;

  logic      ram_we;
  undo_rec_t ram_wdata, ram_rdata;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign pos_ext  = {1'b0, in_data.position};
  assign ins_ok   = (pos_ext <= len_r) && (len_r != LEN_FULL);
  assign del_ok   = (pos_ext < len_r);
  assign rpt_last = ({1'b0, rpt_r} + 1'b1 == len_r);

  // History pointer arithmetic, wrapping at the history depth.
  assign top_inc  = (top_r == TOP_LAST) ? '0 : top_r + 1'b1;
  assign top_dec  = (top_r == '0) ? TOP_LAST : top_r - 1'b1;
  assign cnt_push = (cnt_r == CNT_FULL) ? cnt_r : cnt_r + 1'b1;

  assign rec_pos_ext = {1'b0, ram_rdata.pos};

  // Character under the delete position, taken from the cell row.
  always_comb begin
    gone_ch = '0;
    for (int i = 0; i < TEXT_CAPACITY; i++) begin
      if (pos_ext == LEN_W'(i)) begin
        gone_ch = gone_ch | cell_data[i];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.cmd == CMD_UNDO && cnt_r != '0) begin
          state_nxt = ST_UNDO;
        end else if (accept && in_data.cmd == CMD_REPORT && len_r != '0) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_UNDO: begin
        state_nxt = ST_IDLE;
      end
      ST_REPORT: begin
        if (rpt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath control, bookkeeping and results.
  always_comb begin
    cell_ctl      = '{op: CELL_HOLD, pos: in_data.position, ch: in_data.char_in,
                      len: len_r};
    ram_we        = 1'b0;
    ram_wdata     = '{kind: REC_INSERT, pos: in_data.position, ch: in_data.char_in};
    len_nxt       = len_r;
    top_nxt       = top_r;
    cnt_nxt       = cnt_r;
    rpt_nxt       = rpt_r;
    out_valid_nxt = 1'b0;
    res_base      = '{status: STAT_OK, char_out: '0, char_valid: 1'b0,
                      undo_depth: '0, last: 1'b1};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.cmd)
            CMD_INSERT: begin
              out_valid_nxt = 1'b1;
              if (ins_ok) begin
                cell_ctl.op = CELL_INS;
                len_nxt     = len_r + 1'b1;
                ram_we      = 1'b1;
                top_nxt     = top_inc;
                cnt_nxt     = cnt_push;
              end else begin
                res_base.status = STAT_ERR;
              end
            end
            CMD_DELETE: begin
              out_valid_nxt = 1'b1;
              if (del_ok) begin
                cell_ctl.op    = CELL_DEL;
                len_nxt        = len_r - 1'b1;
                ram_we         = 1'b1;
                ram_wdata.kind = REC_DELETE;
                ram_wdata.ch   = gone_ch;
                top_nxt        = top_inc;
                cnt_nxt        = cnt_push;
              end else begin
                res_base.status = STAT_ERR;
              end
            end
            CMD_UNDO: begin
              if (cnt_r != '0) begin
                top_nxt = top_dec;
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                out_valid_nxt   = 1'b1;
                res_base.status = STAT_ERR;
              end
            end
            CMD_REPORT: begin
              rpt_nxt = '0;
              if (len_r == '0) begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_UNDO: begin
        // Reverse the popped record when it fits the current string.
        out_valid_nxt = 1'b1;
        cell_ctl.pos  = ram_rdata.pos;
        cell_ctl.ch   = ram_rdata.ch;
        if (ram_rdata.kind == REC_INSERT) begin
          if (rec_pos_ext < len_r) begin
            cell_ctl.op = CELL_DEL;
            len_nxt     = len_r - 1'b1;
          end
        end else if (rec_pos_ext <= len_r && len_r != LEN_FULL) begin
          cell_ctl.op = CELL_INS;
          len_nxt     = len_r + 1'b1;
        end
      end
      ST_REPORT: begin
        // Stream cell 0 while the row rotates left over the string.
        cell_ctl.op         = CELL_ROT;
        out_valid_nxt       = 1'b1;
        res_base.char_out   = cell_data[0];
        res_base.char_valid = 1'b1;
        res_base.last       = rpt_last;
        rpt_nxt             = rpt_r + 1'b1;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // The depth reported is the count after this step, cut to the field width.
  assign cnt_ext = (CW + 5)'(cnt_nxt);
  always_comb begin
    res_nxt            = res_base;
    res_nxt.undo_depth = cnt_ext[DEPTH_W-1:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      top_r       <= '0;
      cnt_r       <= '0;
      rpt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      top_r       <= top_nxt;
      cnt_r       <= cnt_nxt;
      rpt_r       <= rpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Row of text cells.
  for (genvar g = 0; g < TEXT_CAPACITY; g++) begin : g_cell
    cbe_cell #(
      .IDX(g)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .left_data (cell_data[(g > 0) ? g - 1 : 0]),
      .right_data(cell_data[(g < TEXT_CAPACITY - 1) ? g + 1 : g]),
      .first_data(cell_data[0]),
      .data_r    (cell_data[g])
    );
  end

  // Undo history, read at the record below the top.
  cbe_ram #(
    .WIDTH($bits(undo_rec_t)),
    .DEPTH(UNDO_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(top_r),
    .wdata(ram_wdata),
    .raddr(top_dec),
    .rdata(ram_rdata)
  );

endmodule

### hdl/cbe_chk.sv
// ---------------------------------------------------------------------------
// Character buffer editor checker
// Port-level checks of command and result sequencing, bound to the top.
// ---------------------------------------------------------------------------
module cbe_chk
  import cbe_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // An accepted insert or delete gives its single result in the next cycle.
  a_edit_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.cmd == CMD_INSERT || in_data.cmd == CMD_DELETE)
    |=> out_valid && out_data.last && !out_data.char_valid)
    else $error("edit transfer did not give one result in the next cycle");

  // After any accepted command, either a result or ongoing work follows.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted command gave neither a result nor busy");

  // A report stream continues without gaps until its last character.
  a_report_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid && out_data.char_valid)
    else $error("report stream broke before its last character");

  // Report characters always carry OK status.
  a_report_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.char_valid |-> out_data.status == STAT_OK)
    else $error("report character with error status");

endmodule

bind char_buffer_edit_with_undo cbe_chk u_cbe_chk (.*);

### test/char_buffer_edit_with_undo_tb.sv
// ---------------------------------------------------------------------------
// Character buffer editor with undo: testbench
// Drives insert, delete, undo and report commands through the start/busy
// handshake and checks every result strobe against an in-bench model of the
// text row and the undo history. Directed tests cover the empty buffer, the
// ends of the string, the full string and history wrap. Random phases then
// run with varying sender idle rates.
// ---------------------------------------------------------------------------
module char_buffer_edit_with_undo_tb;
  import cbe_pkg::*;

  localparam int CAP   = TEXT_CAPACITY_DEF;
  localparam int HDEPTH = UNDO_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  char_buffer_edit_with_undo dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the editor state.
  logic [CHAR_W-1:0] text_row [CAP];
  int                text_len;
  undo_rec_t         history [HDEPTH];
  int                hist_top;
  int                hist_count;

  // Results still to come, oldest first.
  out_t expected_results [$];
  int   fail_count;
  // Percentage of transfers preceded by a sender gap.
  int   sender_idle_pct;

  // Opens a gap at p and writes c there.
  function automatic void open_gap(int p, logic [CHAR_W-1:0] c);
    for (int i = text_len; i > p; i--) text_row[i] = text_row[i-1];
    text_row[p] = c;
    text_len++;
  endfunction

  // Removes the character at p.
  function automatic void close_gap(int p);
    for (int i = p; i + 1 < text_len; i++) text_row[i] = text_row[i+1];
    text_len--;
  endfunction

  // Pushes an edit record; when the history is full the oldest is overwritten.
  function automatic void push_history(logic kind, int p, logic [CHAR_W-1:0] c);
    history[hist_top].kind = kind;
    history[hist_top].pos  = p[POS_W-1:0];
    history[hist_top].ch   = c;
    hist_top = (hist_top + 1) % HDEPTH;
    if (hist_count < HDEPTH) hist_count++;
  endfunction

  // Applies one accepted command to the model and queues its results.
  function automatic void predict_results(in_t item);
    out_t      res;
    int        p;
    undo_rec_t rec;
    logic [CHAR_W-1:0] gone;
    res = '0;
    res.status = STAT_OK;
    res.last = 1'b1;
    p = item.position;
    case (item.cmd)
      CMD_REPORT: begin
        if (text_len != 0) begin
          for (int i = 0; i < text_len; i++) begin
            res.char_out   = text_row[i];
            res.char_valid = 1'b1;
            res.undo_depth = hist_count[DEPTH_W-1:0];
            res.last       = (i + 1 == text_len);
            expected_results.push_back(res);
          end
          return;
        end
      end
      CMD_INSERT: begin
        if (p > text_len || text_len + 1 >= CAP) begin
          res.status = STAT_ERR;
        end else begin
          open_gap(p, item.char_in);
          push_history(REC_INSERT, p, item.char_in);
        end
      end
      CMD_DELETE: begin
        if (p >= text_len) begin
          res.status = STAT_ERR;
        end else begin
          gone = text_row[p];
          close_gap(p);
          push_history(REC_DELETE, p, gone);
        end
      end
      default: begin
        if (hist_count == 0) begin
          res.status = STAT_ERR;
        end else begin
          hist_top = (hist_top + HDEPTH - 1) % HDEPTH;
          hist_count--;
          rec = history[hist_top];
          // A record that no longer fits is popped with no change to the text.
          if (rec.kind == REC_INSERT) begin
            if (rec.pos < text_len) close_gap(rec.pos);
          end else if (rec.pos <= text_len && text_len + 1 < CAP) begin
            open_gap(rec.pos, rec.ch);
          end
        end
      end
    endcase
    res.undo_depth = hist_count[DEPTH_W-1:0];
    expected_results.push_back(res);
  endfunction

  // Sends one command, with a random sender gap first, and predicts it once
  // the transfer has taken place.
  task automatic send_cmd(cmd_t cmd, int p, int c);
    in_t item;
    int  gap;
    item.cmd      = cmd;
    item.position = p[POS_W-1:0];
    item.char_in  = c[CHAR_W-1:0];
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_results(item);
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Compares one result field and records a mismatch.
  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Each result strobe is checked against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, out_data.status);
        compare_field("char_out", want.char_out, out_data.char_out);
        compare_field("char_valid", want.char_valid, out_data.char_valid);
        compare_field("undo_depth", want.undo_depth, out_data.undo_depth);
        compare_field("last", want.last, out_data.last);
      end
    end
  end

  // Report, undo, delete and out-of-range insert on an empty buffer.
  task automatic test_empty_buffer();
    send_cmd(CMD_REPORT, 0, 0);
    send_cmd(CMD_UNDO, 0, 0);
    send_cmd(CMD_DELETE, 0, 0);
    send_cmd(CMD_INSERT, 1, 8'h41);
  endtask

  // Edits at the head, tail and middle, bad indices and undo of both kinds.
  task automatic test_basic_edits();
    send_cmd(CMD_INSERT, 0, 8'h41);
    send_cmd(CMD_INSERT, 1, 8'hFF);
    send_cmd(CMD_INSERT, 0, 8'h00);
    send_cmd(CMD_INSERT, 1, 8'h80);
    send_cmd(CMD_REPORT, 63, 8'hFF);
    send_cmd(CMD_DELETE, 3, 0);
    send_cmd(CMD_DELETE, 0, 0);
    send_cmd(CMD_INSERT, 5, 8'h55);
    send_cmd(CMD_DELETE, 63, 0);
    send_cmd(CMD_REPORT, 0, 0);
    send_cmd(CMD_UNDO, 42, 8'hAA);
    send_cmd(CMD_UNDO, 0, 0);
    send_cmd(CMD_REPORT, 0, 0);
    send_cmd(CMD_UNDO, 0, 0);
    send_cmd(CMD_REPORT, 0, 0);
  endtask

  // Fills the string to capacity minus one, then checks that inserts are
  // refused and that a full report streams every character.
  task automatic test_full_text();
    while (text_len < CAP - 1)
      send_cmd(CMD_INSERT, $urandom_range(text_len, 0), $urandom_range(255, 0));
    send_cmd(CMD_INSERT, 0, 8'h11);
    send_cmd(CMD_INSERT, 63, 8'h22);
    send_cmd(CMD_REPORT, 0, 0);
    send_cmd(CMD_DELETE, 63, 0);
    send_cmd(CMD_DELETE, 62, 0);
    send_cmd(CMD_INSERT, 62, 8'hC3);
  endtask

  // The history has wrapped many times: sixteen undos succeed, the next fails.
  task automatic test_history_wrap();
    repeat (HDEPTH + 1) send_cmd(CMD_UNDO, 0, 0);
    send_cmd(CMD_REPORT, 0, 0);
  endtask

  // Random commands, mostly well-formed edits, with some out-of-range indices.
  task automatic test_random_mix(int idle_pct, int count);
    int   k;
    int   p;
    cmd_t cmd;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      k = $urandom_range(99);
      if (k < 42) cmd = CMD_INSERT;
      else if (k < 67) cmd = CMD_DELETE;
      else if (k < 87) cmd = CMD_UNDO;
      else cmd = CMD_REPORT;
      // Keep the string from sitting at capacity for long.
      if (cmd == CMD_INSERT && text_len > 48 && $urandom_range(1) == 1) cmd = CMD_DELETE;
      if ($urandom_range(99) < 15) p = $urandom_range(63, 0);
      else if (cmd == CMD_INSERT) p = $urandom_range(text_len, 0);
      else if (text_len > 0) p = $urandom_range(text_len - 1, 0);
      else p = 0;
      send_cmd(cmd, p, $urandom_range(255, 0));
    end
  endtask

  // Overall run: reset, directed tests, then random phases.
  initial begin
    int waited;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_data         = '0;
    text_len        = 0;
    hist_top        = 0;
    hist_count      = 0;
    fail_count      = 0;
    sender_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_buffer();
    test_basic_edits();
    wait_results_drained();
    sender_idle_pct = 28;
    test_full_text();
    test_history_wrap();
    wait_results_drained();
    test_random_mix(0, 115);
    test_random_mix(59, 115);
    wait_results_drained();
    test_random_mix(28, 115);

    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hdl/cbe_pkg.sv
hdl/cbe_ram.sv
hdl/cbe_cell.sv
hdl/char_buffer_edit_with_undo.sv
hdl/cbe_chk.sv
test/char_buffer_edit_with_undo_tb.sv
